@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the bmp_stream_decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define BMPD_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define BMPD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/bmpd_pkg.sv @@
// types and constants of the bitmap stream decoder
`timescale 1ns / 1ps
package bmpd_pkg;

  // default limits
  localparam int unsigned MaxWidthDef     = 4096;
  localparam int unsigned MaxHeightDef    = 4096;
  localparam int unsigned PaletteDepthDef = 256;

  // file format constants
  localparam logic [15:0] BmpMagic    = 16'd19778;
  localparam logic [31:0] WinHdrEnd   = 32'd54;
  localparam logic [31:0] Os2HdrEnd   = 32'd26;
  localparam logic [31:0] WinInfoSize = 32'd40;
  localparam logic [31:0] Os2InfoSize = 32'd12;

  // result queue depth
  localparam int unsigned FifoDepth = 4;

  // error codes
  localparam logic [2:0] ErrNone        = 3'd0;
  localparam logic [2:0] ErrMagic       = 3'd1;
  localparam logic [2:0] ErrHeaderSize  = 3'd2;
  localparam logic [2:0] ErrCompression = 3'd3;
  localparam logic [2:0] ErrDepth       = 3'd4;
  localparam logic [2:0] ErrDimensions  = 3'd5;
  localparam logic [2:0] ErrPalette     = 3'd6;

  // one result item
  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        is_err;
    logic [2:0]  code;
    logic        done;
    logic        last;
  } res_t;

endpackage

@@ hw/rtl/bmp_stream_decoder.sv @@
// bitmap stream decoder: header parser, palette memory and pixel emitter
//
//   channel   dir   handshake              payload
//   in        in    in_valid_i/in_stall_o  file_byte_i, start_of_file_i
//   out       out   out_valid_o/out_stall_i pixel_x_o .. last_of_item_o
//
// one byte per cycle is accepted while in_stall_o is low; a byte leaves zero, one
// or two results, drained through a four-entry result queue at one per cycle while
// out_stall_i is low; the palette memory has two registered read ports, so a 4-bit
// byte looks up both indices together; 4-bit images are held to the output rate
// rst_ni clears the parser and queue at once; the palette memory is not cleared
// in_stall_o rises when the queue plus the results in flight leave no room for two
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bmp_stream_decoder
  import bmpd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH     = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT    = MaxHeightDef,
  parameter int unsigned PALETTE_DEPTH = PaletteDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  file_byte_i,
  input  logic        start_of_file_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] pixel_x_o,
  output logic [11:0] pixel_y_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic        is_error_o,
  output logic [2:0]  error_code_o,
  output logic        image_done_o,
  output logic        last_of_item_o
);

  localparam int unsigned PalAw = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam logic [12:0] WidthSat  = 13'(MAX_WIDTH + 1);
  localparam logic [12:0] HeightSat = 13'(MAX_HEIGHT + 1);
  localparam logic [31:0] MaxW32    = 32'(MAX_WIDTH);
  localparam logic [31:0] MaxH32    = 32'(MAX_HEIGHT);
  localparam logic [31:0] WinBig    = 32'(4 * (PALETTE_DEPTH + 1));
  localparam logic [31:0] Os2Big    = 32'(3 * (PALETTE_DEPTH + 1));
  localparam logic [12:0] PalDepth13 = 13'(PALETTE_DEPTH);
  localparam int unsigned QAw = $clog2(FifoDepth);
  localparam int unsigned QCw = $clog2(FifoDepth + 1);
  localparam logic [QCw-1:0] QRoom = QCw'(FifoDepth - 2);

  typedef enum logic [3:0] {
    PH_FILE, PH_SIZE, PH_INFO, PH_PAL, PH_PIX, PH_PAD, PH_DONE, PH_ERR
  } phase_e;

  // parser state
  phase_e      phase_q, phase_d;
  logic [5:0]  pbc_q, pbc_d, cnt;
  logic [31:0] fa_q, fa_d;
  logic [31:0] doff_q, doff_d;
  logic        kind_q, kind_d;
  logic [12:0] width_q, width_d, height_q, height_d;
  logic [4:0]  bpp_q, bpp_d;
  logic [8:0]  palcnt_q, palcnt_d;
  logic [12:0] col_q, col_d, col1;
  logic [12:0] row_q, row_d;
  logic [1:0]  rbp_q, rbp_d, cbp_q, cbp_d;
  logic [15:0] pc_q, pc_d;
  logic        compnz_q, compnz_d;

  // stage one (results waiting on palette read data)
  logic [1:0]  s0_n, s1_n_q;
  logic        s0_err, s1_err_q;
  logic [2:0]  s0_code, s1_code_q;
  logic [11:0] s0_x0, s0_x1, s0_y, s1_x0_q, s1_x1_q, s1_y_q;
  logic        s0_done, s1_done_q;
  logic        s0_pal, s1_pal_q;
  logic        s0_inr0, s0_inr1, s1_inr0_q, s1_inr1_q;
  logic [7:0]  s0_idx0, s0_idx1;
  logic [23:0] s0_rgb, s1_rgb_q;

  // palette memory
  logic [23:0] pal_mem [PALETTE_DEPTH];
  logic [23:0] rd0_q, rd1_q;
  logic        mem_we;
  logic [PalAw-1:0] mem_wa;
  logic [23:0] mem_wd;

  // header end checks
  logic        hdr_fin;
  logic [31:0] vfield;
  logic [31:0] diff_win, diff_os2;
  logic        pal_big;
  logic [8:0]  ncol;
  logic [17:0] prod3;
  logic [8:0]  q3;
  logic [10:0] q3x3;

  // result queue
  res_t           q_mem [FifoDepth];
  logic [QAw-1:0] q_wp_q, q_rp_q;
  logic [QCw-1:0] q_cnt_q;
  res_t           r0, r1;
  logic           in_acc, out_acc;

  assign in_stall_o = (q_cnt_q + QCw'(s1_n_q)) > QRoom;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_valid_o = q_cnt_q != '0;
  assign out_acc    = out_valid_o && !out_stall_i;

  // palette entry count from the data offset
  always_comb begin
    diff_win = (doff_q >= WinHdrEnd) ? doff_q - WinHdrEnd : 32'd0;
    diff_os2 = (doff_q >= Os2HdrEnd) ? doff_q - Os2HdrEnd : 32'd0;
    // divide by three with a reciprocal and one correction
    prod3 = 18'(diff_os2[9:0]) * 18'd171;
    q3    = prod3[17:9];
    q3x3  = 11'(q3) * 11'd3;
    if (q3x3 > 11'(diff_os2[9:0])) q3 = q3 - 9'd1;
    if (kind_q) begin
      pal_big = diff_win >= WinBig;
      ncol    = diff_win[10:2];
    end else begin
      pal_big = diff_os2 >= Os2Big;
      ncol    = q3;
    end
  end

  // byte parser
  always_comb begin
    phase_d = phase_q;  pbc_d = pbc_q;   fa_d = fa_q;     doff_d = doff_q;
    kind_d = kind_q;    width_d = width_q; height_d = height_q;
    bpp_d = bpp_q;      palcnt_d = palcnt_q; col_d = col_q; row_d = row_q;
    rbp_d = rbp_q;      cbp_d = cbp_q;   pc_d = pc_q;     compnz_d = compnz_q;
    s0_n = 2'd0; s0_err = 1'b0; s0_code = ErrNone; s0_x0 = '0; s0_x1 = '0;
    s0_y = '0; s0_done = 1'b0; s0_pal = 1'b0; s0_inr0 = 1'b0; s0_inr1 = 1'b0;
    s0_idx0 = '0; s0_idx1 = '0; s0_rgb = '0;
    mem_we = 1'b0; mem_wa = '0; mem_wd = '0;
    hdr_fin = 1'b0; cnt = '0; col1 = '0; vfield = '0;
    if (in_acc) begin
      // start of file clears the parser
      if (start_of_file_i) begin
        phase_d = PH_FILE; pbc_d = '0; fa_d = '0; doff_d = '0; kind_d = 1'b0;
        width_d = '0; height_d = '0; bpp_d = '0; palcnt_d = '0; col_d = '0;
        row_d = '0; rbp_d = '0; cbp_d = '0; pc_d = '0; compnz_d = 1'b0;
      end
      cnt = pbc_d;
      if (phase_d == PH_FILE || phase_d == PH_SIZE || phase_d == PH_INFO) begin
        fa_d  = {file_byte_i, fa_d[31:8]};
        pbc_d = cnt + 6'd1;
      end
      vfield = {16'd0, fa_d[31:16]};
      case (phase_d)
        PH_FILE: begin
          if (cnt == 6'd1 && fa_d[31:16] != BmpMagic) begin
            s0_n = 2'd1; s0_err = 1'b1; s0_code = ErrMagic;
            phase_d = PH_ERR; pbc_d = '0;
          end else if (cnt == 6'd13) begin
            doff_d = fa_d; phase_d = PH_SIZE; pbc_d = '0;
          end
        end
        PH_SIZE: begin
          if (cnt == 6'd3) begin
            if (fa_d == WinInfoSize) begin
              kind_d = 1'b1; phase_d = PH_INFO; pbc_d = '0;
            end else if (fa_d == Os2InfoSize) begin
              kind_d = 1'b0; phase_d = PH_INFO; pbc_d = '0;
            end else begin
              s0_n = 2'd1; s0_err = 1'b1; s0_code = ErrHeaderSize;
              phase_d = PH_ERR; pbc_d = '0;
            end
          end
        end
        PH_INFO: begin
          if (kind_d) begin
            if (cnt == 6'd3) begin
              width_d = (fa_d > MaxW32) ? WidthSat : fa_d[12:0];
            end else if (cnt == 6'd7) begin
              height_d = (fa_d > MaxH32) ? HeightSat : fa_d[12:0];
            end else if (cnt == 6'd11) begin
              bpp_d = (vfield > 32'd31) ? 5'd0 : vfield[4:0];
            end else if (cnt == 6'd15) begin
              compnz_d = fa_d != 32'd0;
            end else if (cnt == 6'd35) begin
              hdr_fin = 1'b1;
            end
          end else begin
            if (cnt == 6'd1) begin
              width_d = (vfield > MaxW32) ? WidthSat : vfield[12:0];
            end else if (cnt == 6'd3) begin
              height_d = (vfield > MaxH32) ? HeightSat : vfield[12:0];
            end else if (cnt == 6'd7) begin
              bpp_d = (vfield > 32'd31) ? 5'd0 : vfield[4:0];
              compnz_d = 1'b0;
              hdr_fin = 1'b1;
            end
          end
        end
        PH_PAL: begin
          case (cbp_d)
            2'd0: begin
              pc_d = {8'd0, file_byte_i}; cbp_d = 2'd1;
            end
            2'd1: begin
              pc_d = {file_byte_i, pc_d[7:0]}; cbp_d = 2'd2;
            end
            2'd2: begin
              if (col_d < PalDepth13) begin
                mem_we = 1'b1; mem_wa = col_d[PalAw-1:0];
                mem_wd = {file_byte_i, pc_d};
              end
              cbp_d = 2'd3;
            end
            default: cbp_d = 2'd3;
          endcase
          // entry done after the red byte (os/2) or the pad byte (windows)
          if ((cbp_q == 2'd2 && !kind_d) || cbp_q == 2'd3) begin
            cbp_d = 2'd0;
            col_d = col_d + 13'd1;
            if (col_d >= 13'(palcnt_d)) begin
              col_d = '0; phase_d = PH_PIX; pbc_d = '0;
            end
          end
        end
        PH_PIX: begin
          s0_y  = row_d[11:0];
          rbp_d = rbp_d + 2'd1;
          if (bpp_d == 5'd8) begin
            s0_n = 2'd1; s0_pal = 1'b1; s0_x0 = col_d[11:0];
            s0_idx0 = file_byte_i; s0_inr0 = {1'b0, file_byte_i} < palcnt_d;
            col_d = col_d + 13'd1;
          end else if (bpp_d == 5'd4) begin
            s0_n = 2'd1; s0_pal = 1'b1; s0_x0 = col_d[11:0];
            s0_idx0 = {4'd0, file_byte_i[7:4]};
            s0_inr0 = {5'd0, file_byte_i[7:4]} < palcnt_d;
            col1 = col_d + 13'd1;
            col_d = col1;
            // low nibble is dropped at the end of an odd-width row
            if (col1 < width_d) begin
              s0_n = 2'd2; s0_x1 = col1[11:0];
              s0_idx1 = {4'd0, file_byte_i[3:0]};
              s0_inr1 = {5'd0, file_byte_i[3:0]} < palcnt_d;
              col_d = col1 + 13'd1;
            end
          end else begin
            case (cbp_d)
              2'd0: begin
                pc_d = {8'd0, file_byte_i}; cbp_d = 2'd1;
              end
              2'd1: begin
                pc_d = {file_byte_i, pc_d[7:0]}; cbp_d = 2'd2;
              end
              default: begin
                s0_n = 2'd1; s0_x0 = col_d[11:0]; s0_rgb = {file_byte_i, pc_d};
                cbp_d = 2'd0; col_d = col_d + 13'd1;
              end
            endcase
          end
          // end of row
          if (s0_n != 2'd0 && col_d >= width_d) begin
            if ({1'b0, row_d} + 14'd1 >= {1'b0, height_d}) begin
              s0_done = 1'b1; phase_d = PH_DONE; pbc_d = '0;
            end else begin
              row_d = row_d + 13'd1; col_d = '0; cbp_d = 2'd0;
              phase_d = (rbp_d != 2'd0) ? PH_PAD : PH_PIX; pbc_d = '0;
            end
          end
        end
        PH_PAD: begin
          rbp_d = rbp_d + 2'd1;
          if (rbp_d == 2'd0) begin
            phase_d = PH_PIX; pbc_d = '0;
          end
        end
        default: ;
      endcase
      // header checks in priority order
      if (hdr_fin) begin
        if (compnz_d) begin
          s0_n = 2'd1; s0_err = 1'b1; s0_code = ErrCompression;
          phase_d = PH_ERR; pbc_d = '0;
        end else if (bpp_d != 5'd4 && bpp_d != 5'd8 && bpp_d != 5'd24) begin
          s0_n = 2'd1; s0_err = 1'b1; s0_code = ErrDepth;
          phase_d = PH_ERR; pbc_d = '0;
        end else if (width_d == '0 || width_d > 13'(MAX_WIDTH) ||
                     height_d == '0 || height_d > 13'(MAX_HEIGHT)) begin
          s0_n = 2'd1; s0_err = 1'b1; s0_code = ErrDimensions;
          phase_d = PH_ERR; pbc_d = '0;
        end else if (pal_big) begin
          s0_n = 2'd1; s0_err = 1'b1; s0_code = ErrPalette;
          phase_d = PH_ERR; pbc_d = '0;
        end else begin
          palcnt_d = ncol; col_d = '0; cbp_d = 2'd0;
          phase_d = (ncol != '0) ? PH_PAL : PH_PIX; pbc_d = '0;
        end
      end
    end
  end

  // parser and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FILE; pbc_q <= '0; fa_q <= '0; doff_q <= '0; kind_q <= 1'b0;
      width_q <= '0; height_q <= '0; bpp_q <= '0; palcnt_q <= '0; col_q <= '0;
      row_q <= '0; rbp_q <= '0; cbp_q <= '0; pc_q <= '0; compnz_q <= 1'b0;
      s1_n_q <= '0;
    end else begin
      phase_q <= phase_d; pbc_q <= pbc_d; fa_q <= fa_d; doff_q <= doff_d;
      kind_q <= kind_d; width_q <= width_d; height_q <= height_d; bpp_q <= bpp_d;
      palcnt_q <= palcnt_d; col_q <= col_d; row_q <= row_d; rbp_q <= rbp_d;
      cbp_q <= cbp_d; pc_q <= pc_d; compnz_q <= compnz_d;
      s1_n_q <= s0_n;
    end
  end

  // stage one payload
  always_ff @(posedge clk_i) begin
    s1_err_q <= s0_err; s1_code_q <= s0_code; s1_x0_q <= s0_x0; s1_x1_q <= s0_x1;
    s1_y_q <= s0_y; s1_done_q <= s0_done; s1_pal_q <= s0_pal;
    s1_inr0_q <= s0_inr0; s1_inr1_q <= s0_inr1; s1_rgb_q <= s0_rgb;
  end

  // palette memory, one write and two registered reads
  always_ff @(posedge clk_i) begin
    if (mem_we) pal_mem[mem_wa] <= mem_wd;
    if (in_acc) begin
      rd0_q <= pal_mem[s0_idx0[PalAw-1:0]];
      rd1_q <= pal_mem[s0_idx1[PalAw-1:0]];
    end
  end

  // results from stage one
  always_comb begin
    r0 = '0;
    r1 = '0;
    if (s1_err_q) begin
      r0.is_err = 1'b1;
      r0.code   = s1_code_q;
    end else begin
      r0.x = s1_x0_q;
      r0.y = s1_y_q;
      {r0.red, r0.green, r0.blue} = s1_pal_q ? (s1_inr0_q ? rd0_q : 24'd0) : s1_rgb_q;
      r0.done = s1_done_q && s1_n_q == 2'd1;
    end
    r0.last = s1_n_q == 2'd1;
    r1.x = s1_x1_q;
    r1.y = s1_y_q;
    {r1.red, r1.green, r1.blue} = s1_inr1_q ? rd1_q : 24'd0;
    r1.done = s1_done_q;
    r1.last = 1'b1;
  end

  // result queue
  always_ff @(posedge clk_i) begin
    if (s1_n_q != 2'd0) q_mem[q_wp_q] <= r0;
    if (s1_n_q == 2'd2) q_mem[q_wp_q + QAw'(1)] <= r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_wp_q <= '0; q_rp_q <= '0; q_cnt_q <= '0;
    end else begin
      q_wp_q  <= q_wp_q + QAw'(s1_n_q);
      q_rp_q  <= q_rp_q + QAw'(out_acc);
      q_cnt_q <= q_cnt_q + QCw'(s1_n_q) - QCw'(out_acc);
    end
  end

  assign pixel_x_o      = q_mem[q_rp_q].x;
  assign pixel_y_o      = q_mem[q_rp_q].y;
  assign red_o          = q_mem[q_rp_q].red;
  assign green_o        = q_mem[q_rp_q].green;
  assign blue_o         = q_mem[q_rp_q].blue;
  assign is_error_o     = q_mem[q_rp_q].is_err;
  assign error_code_o   = q_mem[q_rp_q].code;
  assign image_done_o   = q_mem[q_rp_q].done;
  assign last_of_item_o = q_mem[q_rp_q].last;

  // checks
  `BMPD_ASSERT(a_q_bound, q_cnt_q <= QCw'(FifoDepth))
  `BMPD_ASSERT_IMP(a_err_single, s1_err_q && s1_n_q != 2'd0, s1_n_q == 2'd1)
  `BMPD_ASSERT_IMP(a_err_fields, out_valid_o && is_error_o,
                   error_code_o != ErrNone && !image_done_o && pixel_x_o == '0)
  `BMPD_ASSERT_IMP(a_no_pal_write_pix, mem_we, phase_q == PH_PAL || start_of_file_i)

endmodule
